FILE: src/hrbp_pkg.sv
package hrbp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int LENGTH_EXT_BITS = LENGTH_BITS + 4;

  localparam logic [4:0] KEY_LEN  = 5'd14;
  localparam logic [4:0] KEY_MISS = 5'd31;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;

  localparam logic [3:0] CLS_NONE    = 4'd0;
  localparam logic [3:0] CLS_METHOD  = 4'd1;
  localparam logic [3:0] CLS_PATH    = 4'd2;
  localparam logic [3:0] CLS_QKEY    = 4'd3;
  localparam logic [3:0] CLS_QVALUE  = 4'd4;
  localparam logic [3:0] CLS_VERSION = 4'd5;
  localparam logic [3:0] CLS_HKEY    = 4'd6;
  localparam logic [3:0] CLS_HVALUE  = 4'd7;
  localparam logic [3:0] CLS_BODY    = 4'd8;

  localparam logic [2:0] STATUS_PARSING     = 3'd0;
  localparam logic [2:0] STATUS_DONE        = 3'd1;
  localparam logic [2:0] STATUS_INVALID     = 3'd2;
  localparam logic [2:0] STATUS_BAD_METHOD  = 3'd3;
  localparam logic [2:0] STATUS_BAD_PATH    = 3'd4;

  typedef enum logic [4:0] {
    ST_START       = 5'd0,
    ST_METHOD      = 5'd1,
    ST_BEFORE_PATH = 5'd2,
    ST_PATH        = 5'd3,
    ST_BEFORE_QKEY = 5'd4,
    ST_QKEY        = 5'd5,
    ST_BEFORE_QVAL = 5'd6,
    ST_QVAL        = 5'd7,
    ST_BEFORE_VER  = 5'd8,
    ST_VER         = 5'd9,
    ST_HKEY        = 5'd10,
    ST_BEFORE_HVAL = 5'd11,
    ST_HVAL        = 5'd12,
    ST_BODY        = 5'd13,
    ST_GOT_CR      = 5'd14,
    ST_GOT_CRLF    = 5'd15,
    ST_GOT_CRLFCR  = 5'd16,
    ST_DONE        = 5'd17,
    ST_BAD         = 5'd18,
    ST_BAD_METHOD  = 5'd19,
    ST_BAD_PATH    = 5'd20
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  field_class;
    logic        field_end;
    logic [3:0]  ended_class;
    logic [2:0]  status;
    logic [31:0] body_length;
  } out_item_t;

  typedef struct packed {
    parse_state_t           state;
    logic [4:0]             key_match_pos;
    logic                   key_is_length;
    logic                   length_seen;
    logic [LENGTH_BITS-1:0] length_value;
    logic [LENGTH_BITS-1:0] body_remaining;
    logic                   body_to_end;
  } parser_regs_t;

  localparam parser_regs_t REGS_RESET = '{
    state:          ST_START,
    key_match_pos:  5'd0,
    key_is_length:  1'b0,
    length_seen:    1'b0,
    length_value:   '0,
    body_remaining: '0,
    body_to_end:    1'b0
  };

  function automatic logic [7:0] length_key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [4:0] key_step(input logic [4:0] pos, input logic [7:0] c);
    logic [4:0] res;
    if (pos < KEY_LEN && c == length_key_char(pos[3:0])) begin
      res = pos + 5'd1;
    end else begin
      res = KEY_MISS;
    end
    return res;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHAR_SP || c == CHAR_TAB;
  endfunction

endpackage

FILE: src/hrbp_step.sv
module hrbp_step
  import hrbp_pkg::*;
(
  input  parser_regs_t regs,
  input  in_item_t     item,
  output parser_regs_t regs_next,
  output out_item_t    result
);

  parser_regs_t           r;
  parser_regs_t           n;
  logic [7:0]             c;
  logic [3:0]             cls;
  logic [3:0]             ended;
  logic [2:0]             status;
  logic                   upper;
  logic                   digit;
  logic [LENGTH_EXT_BITS-1:0] acc;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [LENGTH_BITS-1:0] len_sat;

  always_comb begin
    r = item.restart ? REGS_RESET : regs;
    n = r;
    c = item.data_byte;
    cls = CLS_NONE;
    ended = CLS_NONE;
    upper = (c >= CHAR_UA) && (c <= CHAR_UZ);
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    acc = ({4'b0, r.length_value} << 3) + ({4'b0, r.length_value} << 1)
        + LENGTH_EXT_BITS'(c - CHAR_ZERO);
    len_sat = (acc[LENGTH_EXT_BITS-1:LENGTH_BITS] != 4'd0) ? '1 : acc[LENGTH_BITS-1:0];
    rem_dec = (r.body_remaining != '0) ? r.body_remaining - LENGTH_BITS'(1) : '0;

    case (r.state)
      ST_START: begin
        if (c == CHAR_CR || c == CHAR_LF || is_blank(c)) begin
        end else if (upper) begin
          cls = CLS_METHOD;
          n.state = ST_METHOD;
        end else begin
          n.state = ST_BAD;
        end
      end
      ST_METHOD: begin
        if (upper) begin
          cls = CLS_METHOD;
        end else if (is_blank(c)) begin
          ended = CLS_METHOD;
          n.state = ST_BEFORE_PATH;
        end else begin
          n.state = ST_BAD_METHOD;
        end
      end
      ST_BEFORE_PATH: begin
        if (is_blank(c)) begin
        end else if (c == CHAR_SLASH) begin
          cls = CLS_PATH;
          n.state = ST_PATH;
        end else begin
          n.state = ST_BAD_PATH;
        end
      end
      ST_PATH: begin
        if (is_blank(c)) begin
          ended = CLS_PATH;
          n.state = ST_BEFORE_VER;
        end else if (c == CHAR_QMARK) begin
          ended = CLS_PATH;
          n.state = ST_BEFORE_QKEY;
        end else begin
          cls = CLS_PATH;
        end
      end
      ST_BEFORE_QKEY: begin
        if (is_blank(c) || c == CHAR_LF || c == CHAR_CR) begin
          n.state = ST_BAD_PATH;
        end else begin
          cls = CLS_QKEY;
          n.state = ST_QKEY;
        end
      end
      ST_QKEY: begin
        if (c == CHAR_EQ) begin
          ended = CLS_QKEY;
          n.state = ST_BEFORE_QVAL;
        end else if (is_blank(c)) begin
          n.state = ST_BAD_PATH;
        end else begin
          cls = CLS_QKEY;
        end
      end
      ST_BEFORE_QVAL: begin
        if (is_blank(c) || c == CHAR_LF || c == CHAR_CR) begin
          n.state = ST_BAD_PATH;
        end else begin
          cls = CLS_QVALUE;
          n.state = ST_QVAL;
        end
      end
      ST_QVAL: begin
        if (c == CHAR_AMP) begin
          ended = CLS_QVALUE;
          n.state = ST_BEFORE_QKEY;
        end else if (is_blank(c)) begin
          ended = CLS_QVALUE;
          n.state = ST_BEFORE_VER;
        end else begin
          cls = CLS_QVALUE;
        end
      end
      ST_BEFORE_VER: begin
        if (!is_blank(c)) begin
          cls = CLS_VERSION;
          n.state = ST_VER;
        end
      end
      ST_VER: begin
        if (c == CHAR_CR) begin
          ended = CLS_VERSION;
          n.state = ST_GOT_CR;
        end else begin
          cls = CLS_VERSION;
        end
      end
      ST_HKEY: begin
        if (c == CHAR_COLON) begin
          ended = CLS_HKEY;
          n.state = ST_BEFORE_HVAL;
          n.key_is_length = (r.key_match_pos == KEY_LEN);
          if (r.key_match_pos == KEY_LEN) begin
            n.length_seen = 1'b1;
            n.length_value = '0;
          end
        end else begin
          cls = CLS_HKEY;
          n.key_match_pos = key_step(r.key_match_pos, c);
        end
      end
      ST_BEFORE_HVAL, ST_HVAL: begin
        if (c == CHAR_CR) begin
          ended = CLS_HVALUE;
          n.key_is_length = 1'b0;
          n.state = ST_GOT_CR;
        end else if (r.state == ST_BEFORE_HVAL && is_blank(c)) begin
        end else begin
          cls = CLS_HVALUE;
          n.state = ST_HVAL;
          if (r.key_is_length) begin
            if (digit) begin
              n.length_value = len_sat;
            end else begin
              n.key_is_length = 1'b0;
            end
          end
        end
      end
      ST_BODY: begin
        cls = CLS_BODY;
        if (r.body_to_end) begin
          if (item.last_byte) begin
            ended = CLS_BODY;
            n.state = ST_DONE;
          end
        end else begin
          n.body_remaining = rem_dec;
          if (rem_dec == '0) begin
            ended = CLS_BODY;
            n.state = ST_DONE;
          end
        end
      end
      ST_GOT_CR: begin
        n.state = (c == CHAR_LF) ? ST_GOT_CRLF : ST_BAD;
      end
      ST_GOT_CRLF: begin
        if (c == CHAR_CR) begin
          n.state = ST_GOT_CRLFCR;
        end else if (is_blank(c)) begin
          n.state = ST_BAD;
        end else begin
          cls = CLS_HKEY;
          n.key_match_pos = key_step(5'd0, c);
          n.state = ST_HKEY;
        end
      end
      ST_GOT_CRLFCR: begin
        if (c == CHAR_LF) begin
          if (r.length_seen) begin
            if (r.length_value != '0) begin
              n.body_remaining = r.length_value;
              n.body_to_end = 1'b0;
              n.state = ST_BODY;
            end else begin
              n.state = ST_DONE;
            end
          end else if (item.last_byte) begin
            n.state = ST_DONE;
          end else begin
            n.body_to_end = 1'b1;
            n.state = ST_BODY;
          end
        end
      end
      default: begin
      end
    endcase

    case (n.state)
      ST_DONE:       status = STATUS_DONE;
      ST_BAD:        status = STATUS_INVALID;
      ST_BAD_METHOD: status = STATUS_BAD_METHOD;
      ST_BAD_PATH:   status = STATUS_BAD_PATH;
      default:       status = STATUS_PARSING;
    endcase

    regs_next = n;
    result.byte_out = c;
    result.field_class = cls;
    result.field_end = (ended != CLS_NONE);
    result.ended_class = ended;
    result.status = status;
    result.body_length = 32'(n.length_value);
  end

endmodule

FILE: src/http_request_byte_parser.sv
// http request byte parser
// item channel (item_valid / item_ready / item) carries one request byte per
// transfer, with last_byte marking the end of the message and restart
// returning the parser to its start state before that byte is parsed.
// result channel (result_valid / result_ready / result) gives exactly one
// result per byte: the byte, its field class, field end mark, status and
// the accumulated content length.
// each result is registered, into the result register or, while that is held, the skid register.
// throughput: one byte per cycle while item_ready is high; the parse step is a single pass of
// logic from the state register and input byte into the result or skid register.
// a two-entry output stage (result register plus skid register) lets the
// block keep taking bytes while a result waits; item_ready is registered
// and drops only when both entries are full.
// reset: parse state returns to start, both output entries are emptied.
// stalls on result_ready hold the presented result unchanged.
module http_request_byte_parser
  import hrbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result
);

  parser_regs_t regs;
  parser_regs_t regs_next;
  out_item_t    step_result;
  out_item_t    out_data;
  out_item_t    skid_data;
  logic         out_valid;
  logic         skid_valid;
  logic         item_take;
  logic         result_take;

  hrbp_step u_step (
    .regs      (regs),
    .item      (item),
    .regs_next (regs_next),
    .result    (step_result)
  );

  assign item_ready   = !skid_valid;
  assign item_take    = item_valid && !skid_valid;
  assign result_take  = out_valid && result_ready;
  assign result_valid = out_valid;
  assign result       = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REGS_RESET;
    end else if (item_take) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result_take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= item_take;
        if (item_take) begin
          out_data <= step_result;
        end
      end
    end else if (item_take) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= step_result;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= step_result;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while result entry empty");

  a_body_count_live: assert property (@(posedge clk) disable iff (rst)
    (regs.state == ST_BODY && !regs.body_to_end) |-> regs.body_remaining != '0)
    else $error("counted body with zero bytes left");

  a_length_key_seen: assert property (@(posedge clk) disable iff (rst)
    regs.key_is_length |-> regs.length_seen)
    else $error("length value active without length header");

  a_key_pos_range: assert property (@(posedge clk) disable iff (rst)
    (regs.key_match_pos <= KEY_LEN) || (regs.key_match_pos == KEY_MISS))
    else $error("key match position out of range");

  a_transfer_fills: assert property (@(posedge clk) disable iff (rst)
    (item_take && !result_take) |=> out_valid)
    else $error("byte transfer lost its result");

endmodule

FILE: dv/tb_http_request_byte_parser.sv
`timescale 1ns / 1ps

module tb_http_request_byte_parser
  import hrbp_pkg::*;
();

  typedef struct packed {
    logic      on;
    out_item_t val;
  } want_t;

  typedef struct packed {
    in_item_t stim;
    want_t    want;
  } row_t;

  localparam int STUCK_LIMIT = 2000;
  localparam int CALM_TAIL = 120;
  localparam int RANDOM_ITEMS = 800;
  localparam int N_DIRECTED = 28;
  localparam want_t NO_WANT = '0;
  localparam logic [8*14-1:0] LENGTH_KEY = "Content-Length";

  localparam row_t DIRECTED [N_DIRECTED] = '{
    {8'h00, 1'b0, 1'b1, 1'b1, 8'h00, CLS_NONE, 1'b0, CLS_NONE, STATUS_INVALID, 32'd0},
    {8'hFF, 1'b1, 1'b0, 1'b1, 8'hFF, CLS_NONE, 1'b0, CLS_NONE, STATUS_INVALID, 32'd0},
    {"G", 1'b0, 1'b1, 1'b1, "G", CLS_METHOD, 1'b0, CLS_NONE, STATUS_PARSING, 32'd0},
    {"1", 1'b0, 1'b0, 1'b1, "1", CLS_NONE, 1'b0, CLS_NONE, STATUS_BAD_METHOD, 32'd0},
    {"P", 1'b0, 1'b1, 1'b1, "P", CLS_METHOD, 1'b0, CLS_NONE, STATUS_PARSING, 32'd0},
    {CHAR_SP, 1'b0, 1'b0, 1'b1, CHAR_SP, CLS_NONE, 1'b1, CLS_METHOD, STATUS_PARSING, 32'd0},
    {"x", 1'b0, 1'b0, 1'b1, "x", CLS_NONE, 1'b0, CLS_NONE, STATUS_BAD_PATH, 32'd0},
    {CHAR_TAB, 1'b0, 1'b1, 1'b1, CHAR_TAB, CLS_NONE, 1'b0, CLS_NONE, STATUS_PARSING, 32'd0},
    {"A", 1'b0, 1'b0, NO_WANT},
    {CHAR_SP, 1'b0, 1'b0, NO_WANT},
    {CHAR_SLASH, 1'b0, 1'b0, NO_WANT},
    {CHAR_QMARK, 1'b0, 1'b0, NO_WANT},
    {CHAR_SP, 1'b0, 1'b0, NO_WANT},
    {"H", 1'b0, 1'b1, NO_WANT},
    {CHAR_SP, 1'b0, 1'b0, NO_WANT},
    {CHAR_SLASH, 1'b0, 1'b0, NO_WANT},
    {CHAR_SP, 1'b0, 1'b0, NO_WANT},
    {CHAR_CR, 1'b0, 1'b0, NO_WANT},
    {CHAR_CR, 1'b0, 1'b0, NO_WANT},
    {CHAR_LF, 1'b0, 1'b0, NO_WANT},
    {"k", 1'b0, 1'b0, NO_WANT},
    {CHAR_COLON, 1'b0, 1'b0, NO_WANT},
    {CHAR_CR, 1'b0, 1'b0, NO_WANT},
    {CHAR_LF, 1'b0, 1'b0, NO_WANT},
    {CHAR_CR, 1'b0, 1'b0, NO_WANT},
    {"z", 1'b0, 1'b0, NO_WANT},
    {CHAR_LF, 1'b1, 1'b0, NO_WANT},
    {"A", 1'b0, 1'b0, NO_WANT}
  };

  logic      clk;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  want_t     item_want = '0;
  out_item_t guess;

  in_item_t  request_bytes[$];
  want_t     typed_results[$];
  out_item_t pending_results[$];
  in_item_t  req_q[$];

  int unsigned accepted_items = 0;
  int unsigned total_items = 0;
  int unsigned mismatches = 0;
  int stuck_cycles = 0;
  int src_gap = 0;
  int src_quiet = 0;
  int snk_gap = 0;
  int snk_quiet = 0;

  parse_state_t p_state;
  logic [4:0]   p_key_pos;
  logic         p_key_hit;
  logic         p_len_seen;
  logic [31:0]  p_len;
  logic [31:0]  p_body_left;
  logic         p_body_open;

  http_request_byte_parser dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic blank_char(input logic [7:0] c);
    return c == CHAR_SP || c == CHAR_TAB;
  endfunction

  function automatic logic upper_char(input logic [7:0] c);
    return c >= CHAR_UA && c <= CHAR_UZ;
  endfunction

  function automatic void clear_parser();
    p_state = ST_START;
    p_key_pos = 5'd0;
    p_key_hit = 1'b0;
    p_len_seen = 1'b0;
    p_len = 32'd0;
    p_body_left = 32'd0;
    p_body_open = 1'b0;
  endfunction

  function automatic void step_key(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (p_key_pos < KEY_LEN) hit = (c == LENGTH_KEY[8 * (13 - int'(p_key_pos)) +: 8]);
    p_key_pos = hit ? p_key_pos + 5'd1 : KEY_MISS;
  endfunction

  function automatic out_item_t parse_next_byte(input in_item_t it);
    logic [7:0]  c;
    logic [3:0]  cls;
    logic [3:0]  ended;
    logic [31:0] d;
    out_item_t   r;
    c = it.data_byte;
    cls = CLS_NONE;
    ended = CLS_NONE;
    if (it.restart) clear_parser();
    case (p_state)
      ST_START: begin
        if (upper_char(c)) begin
          cls = CLS_METHOD;
          p_state = ST_METHOD;
        end else if (!(c == CHAR_CR || c == CHAR_LF || blank_char(c))) begin
          p_state = ST_BAD;
        end
      end
      ST_METHOD: begin
        if (upper_char(c)) begin
          cls = CLS_METHOD;
        end else if (blank_char(c)) begin
          ended = CLS_METHOD;
          p_state = ST_BEFORE_PATH;
        end else begin
          p_state = ST_BAD_METHOD;
        end
      end
      ST_BEFORE_PATH: begin
        if (c == CHAR_SLASH) begin
          cls = CLS_PATH;
          p_state = ST_PATH;
        end else if (!blank_char(c)) begin
          p_state = ST_BAD_PATH;
        end
      end
      ST_PATH: begin
        if (blank_char(c)) begin
          ended = CLS_PATH;
          p_state = ST_BEFORE_VER;
        end else if (c == CHAR_QMARK) begin
          ended = CLS_PATH;
          p_state = ST_BEFORE_QKEY;
        end else begin
          cls = CLS_PATH;
        end
      end
      ST_BEFORE_QKEY: begin
        if (blank_char(c) || c == CHAR_LF || c == CHAR_CR) begin
          p_state = ST_BAD_PATH;
        end else begin
          cls = CLS_QKEY;
          p_state = ST_QKEY;
        end
      end
      ST_QKEY: begin
        if (c == CHAR_EQ) begin
          ended = CLS_QKEY;
          p_state = ST_BEFORE_QVAL;
        end else if (blank_char(c)) begin
          p_state = ST_BAD_PATH;
        end else begin
          cls = CLS_QKEY;
        end
      end
      ST_BEFORE_QVAL: begin
        if (blank_char(c) || c == CHAR_LF || c == CHAR_CR) begin
          p_state = ST_BAD_PATH;
        end else begin
          cls = CLS_QVALUE;
          p_state = ST_QVAL;
        end
      end
      ST_QVAL: begin
        if (c == CHAR_AMP) begin
          ended = CLS_QVALUE;
          p_state = ST_BEFORE_QKEY;
        end else if (blank_char(c)) begin
          ended = CLS_QVALUE;
          p_state = ST_BEFORE_VER;
        end else begin
          cls = CLS_QVALUE;
        end
      end
      ST_BEFORE_VER: begin
        if (!blank_char(c)) begin
          cls = CLS_VERSION;
          p_state = ST_VER;
        end
      end
      ST_VER: begin
        if (c == CHAR_CR) begin
          ended = CLS_VERSION;
          p_state = ST_GOT_CR;
        end else begin
          cls = CLS_VERSION;
        end
      end
      ST_HKEY: begin
        if (c == CHAR_COLON) begin
          ended = CLS_HKEY;
          p_state = ST_BEFORE_HVAL;
          p_key_hit = (p_key_pos == KEY_LEN);
          if (p_key_hit) begin
            p_len_seen = 1'b1;
            p_len = 32'd0;
          end
        end else begin
          cls = CLS_HKEY;
          step_key(c);
        end
      end
      ST_BEFORE_HVAL, ST_HVAL: begin
        if (c == CHAR_CR) begin
          ended = CLS_HVALUE;
          p_key_hit = 1'b0;
          p_state = ST_GOT_CR;
        end else if (p_state != ST_BEFORE_HVAL || !blank_char(c)) begin
          cls = CLS_HVALUE;
          p_state = ST_HVAL;
          if (p_key_hit) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
              d = {24'd0, c - CHAR_ZERO};
              if (p_len > (32'hFFFF_FFFF - d) / 32'd10) p_len = 32'hFFFF_FFFF;
              else p_len = p_len * 32'd10 + d;
            end else begin
              p_key_hit = 1'b0;
            end
          end
        end
      end
      ST_BODY: begin
        cls = CLS_BODY;
        if (p_body_open) begin
          if (it.last_byte) begin
            ended = CLS_BODY;
            p_state = ST_DONE;
          end
        end else begin
          if (p_body_left != 32'd0) p_body_left = p_body_left - 32'd1;
          if (p_body_left == 32'd0) begin
            ended = CLS_BODY;
            p_state = ST_DONE;
          end
        end
      end
      ST_GOT_CR: begin
        p_state = (c == CHAR_LF) ? ST_GOT_CRLF : ST_BAD;
      end
      ST_GOT_CRLF: begin
        if (c == CHAR_CR) begin
          p_state = ST_GOT_CRLFCR;
        end else if (blank_char(c)) begin
          p_state = ST_BAD;
        end else begin
          cls = CLS_HKEY;
          p_key_pos = 5'd0;
          step_key(c);
          p_state = ST_HKEY;
        end
      end
      ST_GOT_CRLFCR: begin
        if (c == CHAR_LF) begin
          if (p_len_seen) begin
            if (p_len != 32'd0) begin
              p_body_left = p_len;
              p_body_open = 1'b0;
              p_state = ST_BODY;
            end else begin
              p_state = ST_DONE;
            end
          end else if (it.last_byte) begin
            p_state = ST_DONE;
          end else begin
            p_body_open = 1'b1;
            p_state = ST_BODY;
          end
        end
      end
      default: begin
      end
    endcase
    r.byte_out = c;
    r.field_class = cls;
    r.field_end = (ended != CLS_NONE);
    r.ended_class = ended;
    case (p_state)
      ST_DONE:       r.status = STATUS_DONE;
      ST_BAD:        r.status = STATUS_INVALID;
      ST_BAD_METHOD: r.status = STATUS_BAD_METHOD;
      ST_BAD_PATH:   r.status = STATUS_BAD_PATH;
      default:       r.status = STATUS_PARSING;
    endcase
    r.body_length = p_len;
    return r;
  endfunction

  task automatic check_result(input out_item_t want, input out_item_t got);
    if (got.byte_out !== want.byte_out) begin
      $display("%0t: byte_out expected %0d, got %0d", $time, want.byte_out, got.byte_out);
      mismatches++;
    end
    if (got.field_class !== want.field_class) begin
      $display("%0t: field_class expected %0d, got %0d", $time, want.field_class,
               got.field_class);
      mismatches++;
    end
    if (got.field_end !== want.field_end) begin
      $display("%0t: field_end expected %0d, got %0d", $time, want.field_end, got.field_end);
      mismatches++;
    end
    if (got.ended_class !== want.ended_class) begin
      $display("%0t: ended_class expected %0d, got %0d", $time, want.ended_class,
               got.ended_class);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.body_length !== want.body_length) begin
      $display("%0t: body_length expected %0d, got %0d", $time, want.body_length,
               got.body_length);
      mismatches++;
    end
  endtask

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) == 1) ? CHAR_SP : CHAR_TAB;
  endfunction

  function automatic logic [7:0] text_char(input logic [7:0] skip);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(33, 126));
    end while (c == CHAR_CR || c == CHAR_LF || blank_char(c) || c == skip);
    return c;
  endfunction

  task automatic put_byte(input logic [7:0] b);
    in_item_t x;
    x.data_byte = b;
    x.last_byte = 1'b0;
    x.restart = 1'b0;
    req_q.push_back(x);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic add_request();
    string  s;
    int     kind;
    int     n;
    int     hdr_end;
    int     cut;
    longint clen;
    bit     have_len;
    bit     in_digits;
    req_q.delete();
    have_len = 1'b0;
    clen = 0;
    repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(CHAR_UA, CHAR_UZ)));
    repeat ($urandom_range(1, 2)) put_byte(pick_blank());
    put_byte(CHAR_SLASH);
    repeat ($urandom_range(0, 4)) put_byte(text_char(CHAR_QMARK));
    if ($urandom_range(0, 1) == 1) begin
      put_byte(CHAR_QMARK);
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        if (i != 0) put_byte(CHAR_AMP);
        repeat ($urandom_range(1, 3)) put_byte(text_char(CHAR_EQ));
        put_byte(CHAR_EQ);
        repeat ($urandom_range(1, 3)) put_byte(text_char(CHAR_AMP));
      end
    end
    repeat ($urandom_range(1, 2)) put_byte(pick_blank());
    if ($urandom_range(0, 1) == 1) put_text("HTTP/1.1");
    else repeat ($urandom_range(1, 6)) put_byte(text_char(CHAR_CR));
    put_byte(CHAR_CR);
    put_byte(CHAR_LF);
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 3);
      s = "Content-Length";
      if (kind == 2) begin
        repeat ($urandom_range(1, 6)) put_byte(text_char(CHAR_COLON));
      end else begin
        if (kind == 1) begin
          case ($urandom_range(0, 2))
            0: s = s.substr(0, $urandom_range(0, 12));
            1: s = {s, "s"};
            default: begin
              n = $urandom_range(0, 12);
              if (n == 7) n = 13;
              s[n] = s[n] ^ 8'h20;
            end
          endcase
        end
        put_text(s);
      end
      put_byte(CHAR_COLON);
      repeat ($urandom_range(0, 2)) put_byte(pick_blank());
      if (kind == 0 || kind == 3) begin
        have_len = 1'b1;
        case ($urandom_range(0, 6))
          0, 1: s = $sformatf("%0d", $urandom_range(1, 24));
          2: s = ($urandom_range(0, 1) == 1) ? "0" : "007";
          3: s = $sformatf("%0d%0d", $urandom_range(1, 9), $urandom);
          4: s = $sformatf("42949672%0d", $urandom_range(90, 99));
          5: s = $sformatf("%0dx%0d", $urandom_range(0, 9), $urandom_range(0, 9));
          default: s = ($urandom_range(0, 1) == 1) ? "" : "abc";
        endcase
        put_text(s);
        clen = 0;
        in_digits = 1'b1;
        for (int i = 0; i < s.len(); i++) begin
          if (in_digits && s[i] >= "0" && s[i] <= "9") begin
            if (clen < 1000) clen = clen * 10 + (s[i] - "0");
          end else begin
            in_digits = 1'b0;
          end
        end
      end else begin
        repeat ($urandom_range(0, 5)) put_byte(text_char(CHAR_CR));
      end
      put_byte(CHAR_CR);
      put_byte(CHAR_LF);
    end
    hdr_end = req_q.size();
    put_byte(CHAR_CR);
    if ($urandom_range(0, 7) == 0) put_byte(text_char(CHAR_LF));
    put_byte(CHAR_LF);
    if (have_len) begin
      if (clen == 0) repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
      else if (clen <= 24) repeat (clen) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 16)) put_byte(8'($urandom_range(0, 255)));
      req_q[req_q.size() - 1].last_byte = 1'b1;
    end
    req_q[0].restart = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 5) == 0) req_q[$urandom_range(0, hdr_end - 1)].last_byte = 1'b1;
    if ($urandom_range(0, 7) == 0) begin
      req_q[$urandom_range(0, req_q.size() - 1)].data_byte = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, req_q.size());
      while (req_q.size() > cut) void'(req_q.pop_back());
    end
    foreach (req_q[i]) begin
      request_bytes.push_back(req_q[i]);
      typed_results.push_back(NO_WANT);
    end
  endtask

  // byte source
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      src_gap = 0;
    end else if (!item_valid || item_ready) begin
      if (src_gap != 0) begin
        src_gap--;
        item_valid <= 1'b0;
      end else if (request_bytes.size() != 0) begin
        item <= request_bytes.pop_front();
        item_want <= typed_results.pop_front();
        item_valid <= 1'b1;
        if (src_quiet != 0) src_quiet--;
        else if ($urandom_range(0, 31) == 0) src_quiet = $urandom_range(20, 60);
        if (request_bytes.size() >= CALM_TAIL && src_quiet == 0 && $urandom_range(0, 3) == 0)
          src_gap = $urandom_range(1, 7);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      snk_gap = 0;
    end else if (snk_gap != 0) begin
      snk_gap--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      if (snk_quiet != 0) snk_quiet--;
      else if ($urandom_range(0, 31) == 0) snk_quiet = $urandom_range(20, 60);
      if (request_bytes.size() >= CALM_TAIL && snk_quiet == 0 && $urandom_range(0, 4) == 0)
        snk_gap = $urandom_range(1, 7);
    end
  end

  // prediction on each byte transfer, check on each result transfer
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      stuck_cycles = 0;
    end else begin
      if (item_valid && item_ready) begin
        guess = parse_next_byte(item);
        pending_results.push_back(item_want.on ? item_want.val : guess);
        accepted_items++;
      end
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result);
          mismatches++;
        end else begin
          check_result(pending_results.pop_front(), result);
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    in_item_t junk;
    for (int i = 0; i < N_DIRECTED; i++) begin
      request_bytes.push_back(DIRECTED[i].stim);
      typed_results.push_back(DIRECTED[i].want);
    end
    while (request_bytes.size() < N_DIRECTED + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          junk.data_byte = 8'($urandom_range(0, 255));
          junk.last_byte = 1'($urandom_range(0, 1));
          junk.restart = ($urandom_range(0, 3) == 0);
          request_bytes.push_back(junk);
          typed_results.push_back(NO_WANT);
        end
      end
      add_request();
    end
    total_items = request_bytes.size();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (accepted_items != total_items) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
